// ===== rtl/assert_macros.svh =====
// assertion macros used by iso_duration_parser
// each macro expects clk and rst in scope of the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every rising edge outside reset
`define AST_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked at every rising edge outside reset
`define AST_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/idp_pkg.sv =====
// types and constants for the iso duration parser
// no dependencies; used by idp_step and iso_duration_parser
`timescale 1ns / 1ps

package idp_pkg;

  localparam int SPAN_W   = 28;
  localparam int NUM_W    = 30;
  localparam int DCNT_W   = 4;
  localparam int UNIT_W   = 22;
  localparam int CH_W     = 16;

  localparam logic [SPAN_W-1:0] SPAN_RESET = 28'd31622400;

  // seconds per unit
  localparam logic [UNIT_W-1:0] UNIT_WEEK  = 22'd604800;
  localparam logic [UNIT_W-1:0] UNIT_DAY   = 22'd86400;
  localparam logic [UNIT_W-1:0] UNIT_HOUR  = 22'd3600;
  localparam logic [UNIT_W-1:0] UNIT_MIN   = 22'd60;
  localparam logic [UNIT_W-1:0] UNIT_MONTH = 22'd2592000;
  localparam logic [UNIT_W-1:0] UNIT_SEC   = 22'd1;
  localparam logic [UNIT_W-1:0] UNIT_NONE  = 22'd0;

  // character codes
  localparam logic [CH_W-1:0] CH_SPACE = 16'h0020;
  localparam logic [CH_W-1:0] CH_TAB   = 16'h0009;
  localparam logic [CH_W-1:0] CH_CR    = 16'h000D;
  localparam logic [CH_W-1:0] CH_LF    = 16'h000A;
  localparam logic [CH_W-1:0] CH_PLUS  = 16'h002B;
  localparam logic [CH_W-1:0] CH_ZERO  = 16'h0030;
  localparam logic [CH_W-1:0] CH_NINE  = 16'h0039;
  localparam logic [CH_W-1:0] CH_P_UP  = 16'h0050;
  localparam logic [CH_W-1:0] CH_P_LO  = 16'h0070;
  localparam logic [CH_W-1:0] CH_T_UP  = 16'h0054;
  localparam logic [CH_W-1:0] CH_T_LO  = 16'h0074;
  localparam logic [CH_W-1:0] CH_W_UP  = 16'h0057;
  localparam logic [CH_W-1:0] CH_W_LO  = 16'h0077;
  localparam logic [CH_W-1:0] CH_D_UP  = 16'h0044;
  localparam logic [CH_W-1:0] CH_D_LO  = 16'h0064;
  localparam logic [CH_W-1:0] CH_H_UP  = 16'h0048;
  localparam logic [CH_W-1:0] CH_H_LO  = 16'h0068;
  localparam logic [CH_W-1:0] CH_M_UP  = 16'h004D;
  localparam logic [CH_W-1:0] CH_M_LO  = 16'h006D;
  localparam logic [CH_W-1:0] CH_S_UP  = 16'h0053;
  localparam logic [CH_W-1:0] CH_S_LO  = 16'h0073;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_SIGN,
    PH_BODY,
    PH_TRAIL
  } phase_t;

  typedef struct packed {
    phase_t              phase;
    logic                in_time;
    logic                saw_unit;
    logic [DCNT_W-1:0]   digit_count;
    logic [NUM_W-1:0]    number;
    logic [SPAN_W-1:0]   total;
    logic                failed;
  } tok_state_t;

  localparam tok_state_t TOK_CLEAR = '{
    phase:       PH_LEAD,
    in_time:     1'b0,
    saw_unit:    1'b0,
    digit_count: '0,
    number:      '0,
    total:       '0,
    failed:      1'b0
  };

endpackage

// ===== rtl/idp_step.sv =====
// per-character token state update and result evaluation
// depends on idp_pkg
`timescale 1ns / 1ps

module idp_step import idp_pkg::*; #(
  parameter int MAX_DIGITS = 9
) (
  input  tok_state_t        cur,
  input  logic [CH_W-1:0]   ch,
  input  logic [SPAN_W-1:0] max_span,
  output tok_state_t        nxt,
  output logic              ok,
  output logic [SPAN_W-1:0] total_ok
);

  localparam int PROD_W = SPAN_W + UNIT_W;
  localparam int SUM_W  = PROD_W + 1;

  logic                is_blank;
  logic                is_digit;
  logic                is_p;
  logic                is_t;
  logic [UNIT_W-1:0]   unit;
  logic                dig_full;
  logic                num_big;
  logic [PROD_W-1:0]   prod;
  logic [SUM_W-1:0]    sum;
  logic                sum_big;
  logic [NUM_W-1:0]    num_digit;
  phase_t              ph_next;

  // character classes
  always_comb begin
    is_blank = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_CR) || (ch == CH_LF);
    is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    is_p     = (ch == CH_P_UP) || (ch == CH_P_LO);
    is_t     = (ch == CH_T_UP) || (ch == CH_T_LO);
  end

  // unit letter decode, minutes only after a time marker
  always_comb begin
    case (ch) inside
      CH_W_UP, CH_W_LO: unit = UNIT_WEEK;
      CH_D_UP, CH_D_LO: unit = UNIT_DAY;
      CH_H_UP, CH_H_LO: unit = UNIT_HOUR;
      CH_M_UP, CH_M_LO: unit = cur.in_time ? UNIT_MIN : UNIT_MONTH;
      CH_S_UP, CH_S_LO: unit = UNIT_SEC;
      default:          unit = UNIT_NONE;
    endcase
  end

  // number accumulation and total check
  always_comb begin
    dig_full  = cur.digit_count >= DCNT_W'(MAX_DIGITS);
    num_big   = cur.number > {{(NUM_W-SPAN_W){1'b0}}, max_span};
    num_digit = {cur.number[NUM_W-4:0], 3'b000} + {cur.number[NUM_W-2:0], 1'b0}
              + {{(NUM_W-4){1'b0}}, ch[3:0]};
    prod      = PROD_W'(cur.number[SPAN_W-1:0]) * PROD_W'(unit);
    sum       = {{(SUM_W-SPAN_W){1'b0}}, cur.total} + {1'b0, prod};
    sum_big   = sum > {{(SUM_W-SPAN_W){1'b0}}, max_span};
  end

  // next phase
  always_comb begin
    ph_next = cur.phase;
    if (!cur.failed) begin
      unique case (cur.phase)
        PH_LEAD: begin
          if (ch == CH_PLUS) ph_next = PH_SIGN;
          else if (is_p) ph_next = PH_BODY;
        end
        PH_SIGN: begin
          if (is_p) ph_next = PH_BODY;
        end
        PH_BODY: begin
          if (is_blank && cur.digit_count == '0) ph_next = PH_TRAIL;
        end
        PH_TRAIL: ph_next = PH_TRAIL;
        default:  ph_next = cur.phase;
      endcase
    end
  end

  // data fields and failure flag
  always_comb begin
    nxt.phase       = ph_next;
    nxt.in_time     = cur.in_time;
    nxt.saw_unit    = cur.saw_unit;
    nxt.digit_count = cur.digit_count;
    nxt.number      = cur.number;
    nxt.total       = cur.total;
    nxt.failed      = cur.failed;
    if (!cur.failed) begin
      unique case (cur.phase)
        PH_LEAD: begin
          if (!is_blank && ch != CH_PLUS && !is_p) nxt.failed = 1'b1;
        end
        PH_SIGN: begin
          if (!is_p) nxt.failed = 1'b1;
        end
        PH_BODY: begin
          if (is_blank) begin
            if (cur.digit_count != '0) nxt.failed = 1'b1;
          end else if (is_digit) begin
            if (dig_full) begin
              nxt.failed = 1'b1;
            end else begin
              nxt.digit_count = cur.digit_count + 1'b1;
              nxt.number      = num_digit;
            end
          end else if (cur.digit_count == '0) begin
            if (is_t) nxt.in_time = 1'b1;
            else nxt.failed = 1'b1;
          end else if (unit == UNIT_NONE || num_big || sum_big) begin
            nxt.failed = 1'b1;
          end else begin
            nxt.total       = sum[SPAN_W-1:0];
            nxt.saw_unit    = 1'b1;
            nxt.number      = '0;
            nxt.digit_count = '0;
          end
        end
        PH_TRAIL: begin
          if (!is_blank) nxt.failed = 1'b1;
        end
        default: nxt.failed = 1'b1;
      endcase
    end
  end

  // result if this character ends the token
  always_comb begin
    ok = !nxt.failed && (nxt.phase == PH_BODY || nxt.phase == PH_TRAIL)
         && nxt.digit_count == '0 && nxt.saw_unit;
    total_ok = ok ? nxt.total : '0;
  end

endmodule

// ===== rtl/iso_duration_parser.sv =====
// top level of the iso 8601 duration parser: channels, state and result registers
// depends on idp_pkg, idp_step and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage
// Input channel (in_valid/in_ready) carries one character per transaction: ch and
// last, where last marks the final character of a token. Each character passes an
// input register, then the token state update; a last character writes one
// result into the output register (out_valid/out_ready) with valid_res and seconds.
// Characters that are not last produce no result.
// Throughput: one character per cycle while the input register is not held by a
// waiting last character, set by the combinational token state update (one
// constant-unit multiply, an add and compares against max_span).
// Receiver stall: while a result waits, characters that are not last keep flowing;
// a last character holds in the input register until the result is taken, and
// in_ready then drops once that register is full.
// Configuration: cfg_valid/cfg_ready writes max_span, always ready; write it only
// while the block is idle.
// Reset: rst (synchronous, active high) clears the token state, empties both
// registers and sets max_span to 31622400.

module iso_duration_parser import idp_pkg::*; #(
  parameter int MAX_DIGITS = 9
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CH_W-1:0]   ch,
  input  logic              last,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              valid_res,
  output logic [SPAN_W-1:0] seconds,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [SPAN_W-1:0] max_span
);

  logic              span;
  logic [SPAN_W-1:0] span_reg;
  logic              s1_valid;
  logic              s1_valid_next;
  logic [CH_W-1:0]   s1_ch;
  logic              s1_last;
  logic              s1_adv;
  logic              in_acc;
  logic              out_valid_next;
  tok_state_t        st;
  tok_state_t        st_next;
  tok_state_t        st_step;
  logic              step_ok;
  logic [SPAN_W-1:0] step_total;

  assign span = cfg_valid & cfg_ready;

  // configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) span_reg <= SPAN_RESET;
    else if (span) span_reg <= max_span;
  end

  // handshake control
  assign s1_adv         = s1_valid && (!s1_last || !out_valid || out_ready);
  assign in_ready       = !s1_valid || s1_adv;
  assign in_acc         = in_valid && in_ready;
  assign s1_valid_next  = in_acc || (s1_valid && !s1_adv);
  assign out_valid_next = (s1_adv && s1_last) || (out_valid && !out_ready);

  // input register
  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else s1_valid <= s1_valid_next;
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_ch   <= ch;
      s1_last <= last;
    end
  end

  // token state update
  idp_step #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_step (
    .cur      (st),
    .ch       (s1_ch),
    .max_span (span_reg),
    .nxt      (st_step),
    .ok       (step_ok),
    .total_ok (step_total)
  );

  always_comb begin
    st_next = st;
    if (s1_adv) st_next = s1_last ? TOK_CLEAR : st_step;
  end

  always_ff @(posedge clk) begin
    if (rst) st <= TOK_CLEAR;
    else st <= st_next;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else out_valid <= out_valid_next;
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last) begin
      valid_res <= step_ok;
      seconds   <= step_total;
    end
  end

  // checks
  `AST_SAME(a_invalid_zero, out_valid && !valid_res, seconds == '0, "invalid result nonzero")
  `AST_NEXT(a_clear_after_last, s1_adv && s1_last,
            st.phase == PH_LEAD && st.total == '0 && !st.failed, "token state not cleared")
  `AST_SAME(a_stall_cause, !in_ready,
            s1_valid && s1_last && out_valid && !out_ready, "input stalled without cause")

endmodule
